@@ sv/semt_pkg.sv @@
// Types, codes and code helpers shared by the sorted event marker table.
package semt_pkg;

   localparam int IDX_BITS = 12;
   localparam int CNT_BITS = 13;

   localparam logic [1:0] OP_INSERT    = 2'd0;
   localparam logic [1:0] OP_SEEK_FWD  = 2'd1;
   localparam logic [1:0] OP_SEEK_BACK = 2'd2;
   localparam logic [1:0] OP_CLEAR     = 2'd3;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NONE = 2'd3;

   localparam logic CSR_RESET_CODE = 1'b0;
   localparam logic CSR_DISC_CODE  = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] position;
      logic [63:0] marker_code;
      logic [7:0]  marker_class;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  slot;
      logic [63:0] found_position;
      logic [7:0]  found_class;
      logic [8:0]  removed;
      logic [8:0]  fill;
   } rsp_type;

   typedef struct packed {
      logic [63:0] position;
      logic [63:0] code;
      logic [7:0]  cls;
   } entry_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_DELETE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [IDX_BITS-1:0]   target;
      entry_type             new_entry;
      logic [63:0]           position;
      logic [63:0]           code_fold;
      logic [1:0]            operation;
      logic [CNT_BITS-1:0]   count;
   } cmd_type;

   typedef struct packed {
      logic                bnd_found;
      logic [IDX_BITS-1:0] bnd_idx;
      logic                dup;
      logic                run_open;
      logic [CNT_BITS-1:0] run_len;
      logic                hit_found;
      logic [IDX_BITS-1:0] hit_idx;
      logic [63:0]         hit_pos;
      logic [7:0]          hit_cls;
   } acc_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EVAL,
      S_DEL,
      S_FINISH
   } state_type;

   function automatic logic [63:0] norm_code(input logic [63:0] v, input int chars);
      logic [63:0] r;
      logic        live;
      r    = '0;
      live = 1'b1;
      for (int k = 0; k < 8; k++) begin
         if (k >= chars || v[8*k +: 8] == 8'h00) begin
            live = 1'b0;
         end
         if (live) begin
            r[8*k +: 8] = v[8*k +: 8];
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] fold_code(input logic [63:0] v);
      logic [63:0] r;
      r = v;
      for (int k = 0; k < 8; k++) begin
         if (v[8*k +: 8] >= 8'h41 && v[8*k +: 8] <= 8'h5a) begin
            r[8*k +: 8] = v[8*k +: 8] + 8'h20;
         end
      end
      return r;
   endfunction

endpackage

@@ sv/semt_cell.sv @@
// One table cell: holds one entry, shifts with its neighbors and updates the scan accumulator.
module semt_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  semt_pkg::cmd_type   cmd,
   input  semt_pkg::entry_type left_entry,
   input  semt_pkg::entry_type right_entry,
   input  semt_pkg::acc_type   acc_in,
   output semt_pkg::entry_type entry_out,
   output semt_pkg::acc_type   acc_out
);

   localparam logic [semt_pkg::IDX_BITS-1:0] MY_IDX = semt_pkg::IDX_BITS'(CELL_INDEX);

   semt_pkg::entry_type entry_ff, entry_in;
   semt_pkg::acc_type   acc_ff, acc_in_next;
   logic                valid, match, eq_pos;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.kind)
         semt_pkg::CMD_INSERT: begin
            if (MY_IDX > cmd.target) begin
               entry_in = left_entry;
            end else if (MY_IDX == cmd.target) begin
               entry_in = cmd.new_entry;
            end
         end
         semt_pkg::CMD_DELETE: begin
            if (MY_IDX >= cmd.target) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_comb begin
      valid       = semt_pkg::CNT_BITS'(CELL_INDEX) < cmd.count;
      match       = semt_pkg::fold_code(entry_ff.code) == cmd.code_fold;
      eq_pos      = entry_ff.position == cmd.position;
      acc_in_next = acc_in;
      if (!valid) begin
         acc_in_next.run_open = 1'b0;
      end else begin
         if (!acc_in.bnd_found && entry_ff.position >= cmd.position) begin
            acc_in_next.bnd_found = 1'b1;
            acc_in_next.bnd_idx   = MY_IDX;
            acc_in_next.dup       = eq_pos && match;
            acc_in_next.run_open  = eq_pos && match;
            acc_in_next.run_len   = (eq_pos && match) ? semt_pkg::CNT_BITS'(1) : '0;
         end else if (acc_in.bnd_found && acc_in.run_open) begin
            if (eq_pos && match) begin
               acc_in_next.run_len = acc_in.run_len + 1'b1;
            end else begin
               acc_in_next.run_open = 1'b0;
            end
         end
         if (match) begin
            if ((cmd.operation == semt_pkg::OP_SEEK_FWD && !acc_in.hit_found &&
                 entry_ff.position > cmd.position) ||
                (cmd.operation == semt_pkg::OP_SEEK_BACK &&
                 entry_ff.position < cmd.position)) begin
               acc_in_next.hit_found = 1'b1;
               acc_in_next.hit_idx   = MY_IDX;
               acc_in_next.hit_pos   = entry_ff.position;
               acc_in_next.hit_cls   = entry_ff.cls;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      acc_ff   <= acc_in_next;
   end

   assign entry_out = entry_ff;
   assign acc_out   = acc_ff;

endmodule

@@ sv/sorted_event_marker_table.sv @@
// Top level of the sorted event marker table: cell chain and operation sequencer.
// Operation: a request scans the cell chain, is evaluated and, on a clear, deletes the
// removed entries one at a time; the scan result comes from the accumulator that walks the
// cell chain one cell per cycle. Throughput: one request at a time; the next is taken once
// the previous result is loaded.
// Reset: synchronous active-high reset empties the table (fill count zero) and clears the
// protected code registers; no clearing pass is needed.
module sorted_event_marker_table #(
   parameter int TABLE_DEPTH = 256,
   parameter int CODE_CHARS  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  semt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output semt_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [63:0]       csr_data
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);
   localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_DEPTH - 1);

   semt_pkg::state_type state_ff, state_in;
   logic [IW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       del_left_ff, del_left_in;
   logic [IW-1:0]       del_at_ff, del_at_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         reset_code_ff, disc_code_ff;
   semt_pkg::req_type   req_ff, req_in;
   logic [63:0]         fold_ff, fold_in;
   semt_pkg::rsp_type   res_ff, res_in;
   semt_pkg::rsp_type   rsp_ff, rsp_in;
   semt_pkg::cmd_type   cmd;
   semt_pkg::acc_type   acc_w [TABLE_DEPTH];
   semt_pkg::entry_type entry_w [TABLE_DEPTH];
   semt_pkg::acc_type   res_acc;
   logic [IW-1:0]       ins_idx;
   logic                prot;
   logic [CW-1:0]       run_len;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      semt_pkg::entry_type left_e, right_e;
      semt_pkg::acc_type   acc_i;
      if (k == 0) begin : g_first
         assign left_e = '0;
         assign acc_i  = '0;
      end else begin : g_mid
         assign left_e = entry_w[k-1];
         assign acc_i  = acc_w[k-1];
      end
      if (k == TABLE_DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_nlast
         assign right_e = entry_w[k+1];
      end
      semt_cell #(.CELL_INDEX(k)) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_entry  (left_e),
         .right_entry (right_e),
         .acc_in      (acc_i),
         .entry_out   (entry_w[k]),
         .acc_out     (acc_w[k])
      );
   end

   assign res_acc = acc_w[TABLE_DEPTH-1];
   assign ins_idx = res_acc.bnd_found ? IW'(res_acc.bnd_idx) : IW'(count_ff);
   assign run_len = CW'(res_acc.run_len);
   assign prot    = (semt_pkg::fold_code(semt_pkg::norm_code(reset_code_ff, CODE_CHARS))
                     == fold_ff) ||
                    (semt_pkg::fold_code(semt_pkg::norm_code(disc_code_ff, CODE_CHARS))
                     == fold_ff);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      count_in       = count_ff;
      del_left_in    = del_left_ff;
      del_at_in      = del_at_ff;
      req_in         = req_ff;
      fold_in        = fold_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      req_ready      = state_ff == semt_pkg::S_IDLE;
      cmd.kind       = semt_pkg::CMD_HOLD;
      cmd.target     = '0;
      cmd.new_entry.position = req_ff.position;
      cmd.new_entry.code     = req_ff.marker_code;
      cmd.new_entry.cls      = req_ff.marker_class;
      cmd.position   = req_ff.position;
      cmd.code_fold  = fold_ff;
      cmd.operation  = req_ff.operation;
      cmd.count      = semt_pkg::CNT_BITS'(count_ff);
      case (state_ff)
         semt_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in             = req_payload;
               req_in.marker_code = semt_pkg::norm_code(req_payload.marker_code, CODE_CHARS);
               fold_in            = semt_pkg::fold_code(req_in.marker_code);
               cnt_in             = '0;
               state_in           = semt_pkg::S_SCAN;
            end
         end
         semt_pkg::S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = semt_pkg::S_EVAL;
            end
         end
         semt_pkg::S_EVAL: begin
            res_in   = '0;
            state_in = semt_pkg::S_FINISH;
            case (req_ff.operation)
               semt_pkg::OP_INSERT: begin
                  if (res_acc.bnd_found && res_acc.dup) begin
                     res_in.status = semt_pkg::ST_DUP;
                     res_in.slot   = 8'(ins_idx);
                  end else if (count_ff >= DEPTH_CNT) begin
                     res_in.status = semt_pkg::ST_FULL;
                  end else begin
                     cmd.kind      = semt_pkg::CMD_INSERT;
                     cmd.target    = semt_pkg::IDX_BITS'(ins_idx);
                     count_in      = count_ff + 1'b1;
                     res_in.status = semt_pkg::ST_DONE;
                     res_in.slot   = 8'(ins_idx);
                  end
               end
               semt_pkg::OP_SEEK_FWD, semt_pkg::OP_SEEK_BACK: begin
                  if (res_acc.hit_found) begin
                     res_in.status         = semt_pkg::ST_DONE;
                     res_in.slot           = 8'(res_acc.hit_idx);
                     res_in.found_position = res_acc.hit_pos;
                     res_in.found_class    = res_acc.hit_cls;
                  end else begin
                     res_in.status = semt_pkg::ST_NONE;
                  end
               end
               default: begin
                  if (!prot && run_len != '0) begin
                     res_in.removed = 9'(run_len);
                     del_left_in    = run_len;
                     del_at_in      = IW'(res_acc.bnd_idx);
                     state_in       = semt_pkg::S_DEL;
                  end
               end
            endcase
         end
         semt_pkg::S_DEL: begin
            cmd.kind    = semt_pkg::CMD_DELETE;
            cmd.target  = semt_pkg::IDX_BITS'(del_at_ff);
            count_in    = count_ff - 1'b1;
            del_left_in = del_left_ff - 1'b1;
            if (del_left_ff == CW'(1)) begin
               state_in = semt_pkg::S_FINISH;
            end
         end
         semt_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_in.fill  = 9'(count_ff);
               rsp_valid_in = 1'b1;
               state_in     = semt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = semt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= semt_pkg::S_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         reset_code_ff <= '0;
         disc_code_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            if (csr_index == semt_pkg::CSR_RESET_CODE) begin
               reset_code_ff <= csr_data;
            end else begin
               disc_code_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      del_left_ff <= del_left_in;
      del_at_ff   <= del_at_in;
      req_ff      <= req_in;
      fold_ff     <= fold_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("fill count above table depth");

   a_del_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == semt_pkg::S_DEL) |-> (del_left_ff != '0))
      else $error("delete pass with nothing left to remove");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == semt_pkg::S_SCAN))
      else $error("accepted request did not start a scan");

endmodule

@@ tb/tb_sorted_event_marker_table.sv @@
// Self-checking testbench for the sorted event marker table: random and directed requests.
`timescale 1ns / 100ps

module tb_sorted_event_marker_table;

   localparam int DEPTH = 256;
   localparam int CHARS = 8;
   localparam int LIMIT_CYCLES = 3000000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   semt_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   semt_pkg::rsp_type rsp_payload;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_index;
   logic [63:0]       csr_data;

   sorted_event_marker_table #(.TABLE_DEPTH(DEPTH), .CODE_CHARS(CHARS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   logic [63:0] tbl_pos [DEPTH];
   logic [63:0] tbl_code [DEPTH];
   logic [7:0]  tbl_cls [DEPTH];
   int          tbl_fill;
   logic [63:0] prot_reset_code;
   logic [63:0] prot_disc_code;

   semt_pkg::rsp_type expected_rsps[$];
   int          error_count;
   int          cycle_count;
   int          sent_count;
   int          checked_count;
   bit          rsp_stall_enable;
   logic [63:0] code_pool [8];

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic [63:0] trim_code(input logic [63:0] v);
      logic [63:0] r;
      r = '0;
      for (int k = 0; k < CHARS; k++) begin
         if (v[8*k +: 8] == 8'h00) break;
         r[8*k +: 8] = v[8*k +: 8];
      end
      return r;
   endfunction

   function automatic logic [63:0] lower_code(input logic [63:0] v);
      logic [63:0] r;
      r = v;
      for (int k = 0; k < 8; k++) begin
         if (v[8*k +: 8] inside {[8'h41:8'h5a]}) r[8*k +: 8] = v[8*k +: 8] | 8'h20;
      end
      return r;
   endfunction

   function automatic bit codes_match(input logic [63:0] a, input logic [63:0] b);
      return lower_code(trim_code(a)) == lower_code(trim_code(b));
   endfunction

   function automatic semt_pkg::rsp_type predict_table_op(input semt_pkg::req_type r);
      semt_pkg::rsp_type o;
      logic [63:0] c;
      int          i;
      int          fwd;
      int          back;
      o = '0;
      c = trim_code(r.marker_code);
      fwd = -1;
      back = -1;
      case (r.operation)
         semt_pkg::OP_INSERT: begin
            i = tbl_fill;
            while (i > 0 && tbl_pos[i-1] >= r.position) i--;
            if (i < tbl_fill && tbl_pos[i] == r.position && codes_match(tbl_code[i], c)) begin
               o.status = semt_pkg::ST_DUP;
               o.slot = i[7:0];
            end else if (tbl_fill >= DEPTH) begin
               o.status = semt_pkg::ST_FULL;
            end else begin
               for (int k = tbl_fill; k > i; k--) begin
                  tbl_pos[k] = tbl_pos[k-1];
                  tbl_code[k] = tbl_code[k-1];
                  tbl_cls[k] = tbl_cls[k-1];
               end
               tbl_pos[i] = r.position;
               tbl_code[i] = c;
               tbl_cls[i] = r.marker_class;
               tbl_fill++;
               o.status = semt_pkg::ST_DONE;
               o.slot = i[7:0];
            end
         end
         semt_pkg::OP_SEEK_FWD, semt_pkg::OP_SEEK_BACK: begin
            for (i = 0; i < tbl_fill; i++) begin
               if (!codes_match(tbl_code[i], c)) continue;
               if (tbl_pos[i] > r.position) begin
                  fwd = i;
                  break;
               end
               if (tbl_pos[i] < r.position) back = i;
            end
            i = (r.operation == semt_pkg::OP_SEEK_FWD) ? fwd : back;
            if (i >= 0) begin
               o.status = semt_pkg::ST_DONE;
               o.slot = i[7:0];
               o.found_position = tbl_pos[i];
               o.found_class = tbl_cls[i];
            end else begin
               o.status = semt_pkg::ST_NONE;
            end
         end
         default: begin
            i = 0;
            while (i < tbl_fill && tbl_pos[i] < r.position) i++;
            while (i < tbl_fill && tbl_pos[i] == r.position && codes_match(tbl_code[i], c)) begin
               if (codes_match(tbl_code[i], prot_reset_code) ||
                   codes_match(tbl_code[i], prot_disc_code)) begin
                  i++;
               end else begin
                  for (int k = i; k + 1 < tbl_fill; k++) begin
                     tbl_pos[k] = tbl_pos[k+1];
                     tbl_code[k] = tbl_code[k+1];
                     tbl_cls[k] = tbl_cls[k+1];
                  end
                  tbl_fill--;
                  tbl_pos[tbl_fill] = '0;
                  tbl_code[tbl_fill] = '0;
                  tbl_cls[tbl_fill] = '0;
                  o.removed = o.removed + 9'd1;
               end
            end
            o.status = semt_pkg::ST_DONE;
         end
      endcase
      o.fill = tbl_fill[8:0];
      return o;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb_sorted_event_marker_table: FAIL");
         $finish;
      end
   end

   // random backpressure on results
   always @(posedge clock) begin
      if (reset || !rsp_stall_enable) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_ready <= 1'b0;
      end else if (!rsp_ready && $urandom_range(0, 99) < 10) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      semt_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("response with none expected");
            error_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            checked_count++;
            if (rsp_payload.status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.slot !== exp_rsp.slot) begin
               $error("slot exp %0d got %0d", exp_rsp.slot, rsp_payload.slot);
               error_count++;
            end
            if (rsp_payload.found_position !== exp_rsp.found_position) begin
               $error("found_position exp %h got %h", exp_rsp.found_position,
                      rsp_payload.found_position);
               error_count++;
            end
            if (rsp_payload.found_class !== exp_rsp.found_class) begin
               $error("found_class exp %h got %h", exp_rsp.found_class, rsp_payload.found_class);
               error_count++;
            end
            if (rsp_payload.removed !== exp_rsp.removed) begin
               $error("removed exp %0d got %0d", exp_rsp.removed, rsp_payload.removed);
               error_count++;
            end
            if (rsp_payload.fill !== exp_rsp.fill) begin
               $error("fill exp %0d got %0d", exp_rsp.fill, rsp_payload.fill);
               error_count++;
            end
         end
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [63:0] pos,
                               input logic [63:0] code, input logic [7:0] cls);
      semt_pkg::req_type r;
      int      gap;
      r.operation = op;
      r.position = pos;
      r.marker_code = code;
      r.marker_class = cls;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 2);
      repeat (gap) @(posedge clock);
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.push_back(predict_table_op(r));
      sent_count++;
      req_valid <= 1'b0;
   endtask

   task automatic drain_results();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DEPTH + 20) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [63:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == semt_pkg::CSR_RESET_CODE) prot_reset_code = trim_code(value);
      else prot_disc_code = trim_code(value);
   endtask

   // clear runs that start an equal-position group and are not protected
   task automatic clear_heads(input int limit);
      int j;
      int done;
      done = 0;
      while (done < limit && tbl_fill > 0) begin
         j = 0;
         while (j < tbl_fill && (codes_match(tbl_code[j], prot_reset_code) ||
                codes_match(tbl_code[j], prot_disc_code) ||
                (j > 0 && tbl_pos[j] == tbl_pos[j-1]))) j++;
         if (j >= tbl_fill) break;
         send_request(semt_pkg::OP_CLEAR, tbl_pos[j], tbl_code[j], 8'd0);
         done++;
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] pick_code();
      logic [63:0] c;
      c = code_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 1)) c = c ^ 64'h2020_2020_2020_2020 & c & 64'h4040_4040_4040_4040 >> 1;
      if ($urandom_range(0, 3) == 0) c = lower_code(c);
      if ($urandom_range(0, 7) == 0) c = c | (rand64() & 64'hff00_0000_0000_0000);
      return c;
   endfunction

   task automatic test_directed();
      send_request(semt_pkg::OP_SEEK_FWD, 64'd0, 64'h4b52, 8'd0);
      send_request(semt_pkg::OP_SEEK_BACK, '1, 64'h4b52, 8'd0);
      send_request(semt_pkg::OP_CLEAR, 64'd5, 64'h4b52, 8'd0);
      send_request(semt_pkg::OP_INSERT, 64'd0, 64'h0, 8'h00);
      send_request(semt_pkg::OP_INSERT, '1, '1, 8'hff);
      send_request(semt_pkg::OP_INSERT, 64'd100, 64'h4b52, 8'h41);
      send_request(semt_pkg::OP_INSERT, 64'd100, 64'h6b72, 8'h42);
      send_request(semt_pkg::OP_INSERT, 64'd100, 64'hff00_4b52, 8'h43);
      send_request(semt_pkg::OP_INSERT, 64'd100, 64'h4241, 8'h44);
      send_request(semt_pkg::OP_INSERT, 64'd100, 64'h4b52, 8'h45);
      send_request(semt_pkg::OP_INSERT, 64'd50, 64'h4b52, 8'h46);
      send_request(semt_pkg::OP_INSERT, 64'd200, 64'h6b72, 8'h47);
      send_request(semt_pkg::OP_SEEK_FWD, 64'd100, 64'h4b52, 8'd0);
      send_request(semt_pkg::OP_SEEK_BACK, 64'd100, 64'h6b72, 8'd0);
      send_request(semt_pkg::OP_SEEK_FWD, 64'd100, 64'h4b52_0000_0000_0000, 8'd0);
      send_request(semt_pkg::OP_SEEK_FWD, 64'd0, 64'h0, 8'd0);
      send_request(semt_pkg::OP_CLEAR, 64'd100, 64'h6b72, 8'd0);
      send_request(semt_pkg::OP_CLEAR, '1, '1, 8'd0);
      send_request(semt_pkg::OP_CLEAR, 64'd0, 64'h0, 8'd0);
   endtask

   task automatic test_protected_clear();
      write_csr(semt_pkg::CSR_RESET_CODE, 64'h5253_5444);
      write_csr(semt_pkg::CSR_DISC_CODE, 64'hee00_4353_4944);
      for (int k = 0; k < 3; k++) begin
         send_request(semt_pkg::OP_INSERT, 64'd7, 64'h4e5f_5354, 8'd1);
         send_request(semt_pkg::OP_INSERT, 64'd7, 64'h6473_7472, 8'd2);
         send_request(semt_pkg::OP_INSERT, 64'd7, 64'h6469_7363, 8'd3);
      end
      send_request(semt_pkg::OP_CLEAR, 64'd7, 64'h5253_5444, 8'd0);
      send_request(semt_pkg::OP_CLEAR, 64'd7, 64'h4e5f_5354, 8'd0);
      send_request(semt_pkg::OP_CLEAR, 64'd7, 64'h6469_7363, 8'd0);
   endtask

   task automatic test_full_table();
      drain_results();
      while (tbl_fill < DEPTH)
         send_request(semt_pkg::OP_INSERT, rand64(), rand64(), 8'($urandom()));
      send_request(semt_pkg::OP_INSERT, 64'd3, 64'h41, 8'd9);
      send_request(semt_pkg::OP_INSERT, tbl_pos[0], tbl_code[0], 8'd9);
      send_request(semt_pkg::OP_SEEK_FWD, 64'd0, tbl_code[DEPTH-1], 8'd0);
      send_request(semt_pkg::OP_SEEK_BACK, '1, tbl_code[0], 8'd0);
      send_request(semt_pkg::OP_CLEAR, tbl_pos[10], tbl_code[10], 8'd0);
      send_request(semt_pkg::OP_INSERT, 64'd3, 64'h41, 8'd9);
      clear_heads(60);
   endtask

   task automatic test_random(input int count);
      logic [1:0]  op;
      logic [63:0] pos;
      for (int n = 0; n < count; n++) begin
         op = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 1) == 0) op = semt_pkg::OP_INSERT;
         if ($urandom_range(0, 9) == 0) pos = rand64();
         else if (op != semt_pkg::OP_INSERT && tbl_fill > 0 && $urandom_range(0, 1))
            pos = tbl_pos[$urandom_range(0, tbl_fill - 1)];
         else pos = 64'($urandom_range(0, 40));
         send_request(op, pos, ($urandom_range(0, 15) == 0) ? rand64() : pick_code(),
                      8'($urandom()));
         if (tbl_fill > 200) clear_heads(40);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = 1'b0;
      csr_data = '0;
      rsp_stall_enable = 1'b0;
      error_count = 0;
      cycle_count = 0;
      sent_count = 0;
      checked_count = 0;
      tbl_fill = 0;
      prot_reset_code = '0;
      prot_disc_code = '0;
      for (int k = 0; k < DEPTH; k++) begin
         tbl_pos[k] = '0;
         tbl_code[k] = '0;
         tbl_cls[k] = '0;
      end
      code_pool = '{64'h5253_5444, 64'h4e5f_5354, 64'h4b52, 64'h4949_4e44_4958,
                    64'h4153_4b59_5a61_6d71, 64'h41, 64'h5b40_605b, 64'h6469_7363};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      rsp_stall_enable = 1'b1;
      test_protected_clear();
      test_random(70);
      write_csr(semt_pkg::CSR_RESET_CODE, '1);
      write_csr(semt_pkg::CSR_DISC_CODE, '0);
      test_random(70);
      test_full_table();
      write_csr(semt_pkg::CSR_RESET_CODE, 64'h4b52);
      write_csr(semt_pkg::CSR_DISC_CODE, 64'h5a5a_5a5a_5a5a_5a5a);
      test_random(100);
      drain_results();
      $display("Sent %0d requests, checked %0d responses, table filled to depth %0d.",
               sent_count, checked_count, DEPTH);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("tb_sorted_event_marker_table: PASS");
      end else begin
         $display("tb_sorted_event_marker_table: FAIL");
      end
      $finish;
   end

endmodule
